FILE: hw/rtl/adaptive_threshold_moving_mean_assert.svh
// Assertion macros used by the port-level checker of the threshold block.
`ifndef ADAPTIVE_THRESHOLD_MOVING_MEAN_ASSERT_SVH
`define ADAPTIVE_THRESHOLD_MOVING_MEAN_ASSERT_SVH

// Checked on every rising edge outside reset.
`define ADTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define ADTM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/adtm_pkg.sv
// Package: default parameters and divider constants for the threshold block.
package adtm_pkg;

  // Default window shape and sample width
  localparam int unsigned DEF_PRE_WINDOW   = 8;
  localparam int unsigned DEF_POST_WINDOW  = 7;
  localparam int unsigned DEF_SAMPLE_WIDTH = 32;

  // Quotient bits the divider resolves per cycle
  localparam int unsigned DIV_BITS = 8;

endpackage

FILE: hw/rtl/adtm_stream_if.sv
// Stream interfaces for the sample requests and the result requests.
interface adtm_in_if #(
  parameter int unsigned SAMPLE_WIDTH = adtm_pkg::DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface adtm_out_if #(
  parameter int unsigned SAMPLE_WIDTH = adtm_pkg::DEF_SAMPLE_WIDTH
);
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-2:0] value;
  logic                    last_result;
  logic                    short_frame;

  modport source (output valid, value, last_result, short_frame, input ready);
  modport sink   (input valid, value, last_result, short_frame, output ready);
endinterface

FILE: hw/rtl/adaptive_threshold_moving_mean.sv
// Top level: moving-mean adaptive threshold over one frame of samples.
//
//  channel | dir | payload                             | handshake
//  --------+-----+-------------------------------------+-------------
//  smp_i   | in  | sample, last_sample                 | valid/ready
//  res_o   | out | value, last_result, short_frame     | valid/ready
//
// Steps: a sample without a result passes only the idle and add steps. A result
//   goes on through the window-sum, fetch, radix-2^DIV_BITS mean divide, finish
//   and emit steps, sharing one adder; each tail result of the frame-end flush
//   takes one subtract step (two for the first) before its fetch step.
// Reset: asynchronous, clears the window, the running sum and the count.
// Stalls: results sit in an output register; the sequencer waits in its
//   emit step while that register is full, and takes no sample meanwhile.
// Window shape assumes PRE_WINDOW > POST_WINDOW.
module adaptive_threshold_moving_mean #(
  parameter int unsigned PRE_WINDOW   = adtm_pkg::DEF_PRE_WINDOW,
  parameter int unsigned POST_WINDOW  = adtm_pkg::DEF_POST_WINDOW,
  parameter int unsigned SAMPLE_WIDTH = adtm_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  adtm_in_if.sink    smp_i,
  adtm_out_if.source res_o
);

  localparam int unsigned SW      = SAMPLE_WIDTH;
  localparam int unsigned WIN_LEN = PRE_WINDOW + POST_WINDOW + 1;
  localparam int unsigned IW      = $clog2(WIN_LEN);       // window index / mean length
  localparam int unsigned CW      = $clog2(WIN_LEN + 1);   // sample count, saturating
  localparam int unsigned AGW     = $clog2(POST_WINDOW + 1);
  localparam int unsigned SUMW    = SW + IW + 1;           // signed window sum
  localparam int unsigned DB      = adtm_pkg::DIV_BITS;
  localparam int unsigned DIV_CYC = (SUMW + DB - 1) / DB;
  localparam int unsigned DW      = DIV_CYC * DB;
  localparam int unsigned DCW     = $clog2(DIV_CYC + 1);

  localparam logic [IW-1:0]  IDX_LAST = IW'(WIN_LEN - 1);
  localparam logic [IW-1:0]  IDX_POST = IW'(POST_WINDOW);
  localparam logic [IW-1:0]  LEN_MID  = IW'(WIN_LEN - 1);
  localparam logic [CW-1:0]  CNT_FULL = CW'(WIN_LEN);
  localparam logic [CW-1:0]  POS_HEAD = CW'(POST_WINDOW);
  localparam logic [CW-1:0]  POS_MID  = CW'(2 * POST_WINDOW + 1);
  localparam logic [AGW-1:0] AGE_TOP  = AGW'(POST_WINDOW - 1);
  localparam logic [DCW-1:0] DCNT_END = DCW'(DIV_CYC - 1);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,  // wait for a sample, shift it in, drop the oldest
    ST_ADD  = 8'b0000_0010,  // add the new sample to the running sum
    ST_MID  = 8'b0000_0100,  // head or middle window sum
    ST_TSUB = 8'b0000_1000,  // tail window: peel off old entries one a cycle
    ST_GETX = 8'b0001_0000,  // fetch the centre sample, start the divider
    ST_DIV  = 8'b0010_0000,  // mean = sum / len, DB bits a cycle
    ST_FIN  = 8'b0100_0000,  // sample minus mean, clamp
    ST_EMIT = 8'b1000_0000   // hand the result to the output register
  } state_e;

  state_e state_q, state_d;

  // frame state
  logic signed [SW-1:0] win_q [WIN_LEN];   // newest first
  logic [SUMW-1:0]      ws_q;
  logic [CW-1:0]        cnt_q;
  logic [CW-1:0]        pos_q;
  logic                 last_q;
  logic                 short_q;
  logic                 tail_q;
  logic [AGW-1:0]       age_q;
  logic [IW-1:0]        ridx_q;

  // per-result datapath
  logic [SUMW-1:0]      psum_q;
  logic [IW-1:0]        len_q;
  logic signed [SW-1:0] xv_q;
  logic                 neg_q;
  logic [DW-1:0]        dv_q;
  logic [IW:0]          rem_q;
  logic [DCW-1:0]       dcnt_q;
  logic [SW-2:0]        val_q;

  // output register
  logic                 out_valid_q;
  logic [SW-2:0]        out_value_q;
  logic                 out_last_q;
  logic                 out_short_q;

  logic                 accept;
  logic                 out_free;
  logic                 is_mid;
  logic                 frame_end;
  logic                 tail_start;
  logic [IW-1:0]        tail_len;
  logic [IW-1:0]        rd_idx;
  logic signed [SW-1:0] rd_data;
  logic [SUMW-1:0]      rd_ext;
  logic [SUMW-1:0]      add_a, add_b, add_res;
  logic                 add_sub;
  logic [SUMW-1:0]      abs_sum;
  logic [DW-1:0]        dv_t;
  logic [IW:0]          rem_t;
  logic [SW-2:0]        val_d;

  assign accept   = (state_q == ST_IDLE) && smp_i.valid;
  assign out_free = !out_valid_q || res_o.ready;

  // full frame at end, or past the head: window excludes only the newest sample
  assign is_mid     = last_q || (pos_q >= POS_MID);
  assign frame_end  = short_q || (tail_q && (age_q == '0));
  assign tail_start = last_q && !tail_q && !short_q;
  assign tail_len   = IW'(age_q) + IDX_POST + IW'(1);

  // single read port into the window
  always_comb begin
    case (state_q)
      ST_IDLE: rd_idx = IDX_LAST;
      ST_ADD:  rd_idx = '0;
      ST_MID:  rd_idx = is_mid ? '0 : pos_q[IW-1:0];
      ST_TSUB: rd_idx = ridx_q;
      ST_GETX: rd_idx = tail_q ? IW'(age_q) : IDX_POST;
      default: rd_idx = '0;
    endcase
  end

  assign rd_data = win_q[rd_idx];
  assign rd_ext  = {{(SUMW - SW){rd_data[SW-1]}}, rd_data};

  // shared add/subtract unit
  always_comb begin
    add_a   = ws_q;
    add_b   = rd_ext;
    add_sub = 1'b0;
    case (state_q)
      ST_IDLE: add_sub = 1'b1;
      ST_ADD:  add_sub = 1'b0;
      ST_MID:  add_sub = 1'b1;
      ST_TSUB: begin
        add_a   = psum_q;
        add_sub = 1'b1;
      end
      ST_GETX: begin                     // negate for |sum|
        add_a   = '0;
        add_b   = psum_q;
        add_sub = 1'b1;
      end
      ST_FIN: begin                      // x - mean, mean = +/- quotient
        add_a   = {{(SUMW - SW){xv_q[SW-1]}}, xv_q};
        add_b   = dv_q[SUMW-1:0];
        add_sub = !neg_q;
      end
      default: add_sub = 1'b0;
    endcase
  end

  assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);
  assign abs_sum = psum_q[SUMW-1] ? add_res : psum_q;

  // restoring divider, DB quotient bits per cycle; remainder stays narrow
  always_comb begin
    rem_t = rem_q;
    dv_t  = dv_q;
    for (int i = 0; i < DB; i++) begin
      rem_t = {rem_t[IW-1:0], dv_t[DW-1]};
      dv_t  = {dv_t[DW-2:0], 1'b0};
      if (rem_t >= {1'b0, len_q}) begin
        rem_t   = rem_t - {1'b0, len_q};
        dv_t[0] = 1'b1;
      end
    end
  end

  // clamp to [0, 2^(SW-1)-1]
  always_comb begin
    if (add_res[SUMW-1]) begin
      val_d = '0;
    end else if (|add_res[SUMW-2:SW-1]) begin
      val_d = '1;
    end else begin
      val_d = add_res[SW-2:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (smp_i.valid) state_d = ST_ADD;
      ST_ADD: begin
        if (last_q && (cnt_q != CNT_FULL)) begin
          state_d = ST_EMIT;                       // short frame
        end else if (last_q || (pos_q >= POS_HEAD)) begin
          state_d = ST_MID;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MID:  state_d = ST_GETX;
      ST_TSUB: if (ridx_q == tail_len) state_d = ST_GETX;
      ST_GETX: state_d = ST_DIV;
      ST_DIV:  if (dcnt_q == DCNT_END) state_d = ST_FIN;
      ST_FIN:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          if (frame_end) begin
            state_d = ST_IDLE;
          end else if (tail_q || last_q) begin
            state_d = ST_TSUB;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int k = 0; k < WIN_LEN; k++) win_q[k] <= '0;
      ws_q    <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
      last_q  <= 1'b0;
      short_q <= 1'b0;
      tail_q  <= 1'b0;
      age_q   <= '0;
      ridx_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            for (int k = WIN_LEN - 1; k > 0; k--) win_q[k] <= win_q[k-1];
            win_q[0] <= smp_i.sample;
            ws_q     <= add_res;                  // drop the oldest entry
            pos_q    <= cnt_q;
            cnt_q    <= (cnt_q == CNT_FULL) ? CNT_FULL : cnt_q + CW'(1);
            last_q   <= smp_i.last_sample;
          end
        end
        ST_ADD: begin
          ws_q    <= add_res;
          short_q <= last_q && (cnt_q != CNT_FULL);
        end
        ST_TSUB: ridx_q <= ridx_q - IW'(1);
        ST_EMIT: begin
          if (out_free) begin
            if (frame_end) begin
              for (int k = 0; k < WIN_LEN; k++) win_q[k] <= '0;
              ws_q    <= '0;
              cnt_q   <= '0;
              last_q  <= 1'b0;
              short_q <= 1'b0;
              tail_q  <= 1'b0;
            end else if (tail_q) begin
              age_q <= age_q - AGW'(1);
            end else if (last_q) begin
              tail_q <= 1'b1;
              age_q  <= AGE_TOP;
              ridx_q <= IDX_LAST;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_MID: begin
        psum_q <= add_res;
        len_q  <= is_mid ? LEN_MID : pos_q[IW-1:0];
      end
      ST_TSUB: begin
        psum_q <= add_res;
        len_q  <= tail_len;
      end
      ST_GETX: begin
        xv_q   <= rd_data;
        neg_q  <= psum_q[SUMW-1];
        dv_q   <= DW'(abs_sum);
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      ST_DIV: begin
        dv_q   <= dv_t;
        rem_q  <= rem_t;
        dcnt_q <= dcnt_q + DCW'(1);
      end
      ST_FIN: val_q <= val_d;
      ST_EMIT: begin
        if (out_free && tail_start) psum_q <= ws_q;   // tail starts from the full sum
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EMIT) && out_free) begin
      out_value_q <= short_q ? '0 : val_q;
      out_last_q  <= frame_end;
      out_short_q <= short_q;
    end
  end

  assign smp_i.ready       = (state_q == ST_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.value       = out_value_q;
  assign res_o.last_result = out_last_q;
  assign res_o.short_frame = out_short_q;

endmodule

FILE: hw/rtl/adtm_checker.sv
// Port-level checker for the threshold block, bound to the top level.
`include "adaptive_threshold_moving_mean_assert.svh"

module adtm_checker #(
  parameter int unsigned SAMPLE_WIDTH = adtm_pkg::DEF_SAMPLE_WIDTH
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-2:0] out_value_i,
  input logic                    out_last_i,
  input logic                    out_short_i
);

  // a short frame closes with a single zero result
  `ADTM_ASSERT(a_short_zero, out_valid_i && out_short_i |-> out_last_i && (out_value_i == '0), "short-frame result not zero or not last")

  // after a sample is taken, ready is low in the next cycle
  `ADTM_ASSERT(a_busy_after_req, in_valid_i && in_ready_i |=> !in_ready_i, "sample taken on consecutive cycles")

  // stalled result holds
  `ADTM_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_last_i) && $stable(out_short_i), "stalled result changed")

  // nothing offered while in reset
  `ADTM_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_i, "result offered during reset")

endmodule

bind adaptive_threshold_moving_mean adtm_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_adtm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (smp_i.valid),
  .in_ready_i  (smp_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_value_i (res_o.value),
  .out_last_i  (res_o.last_result),
  .out_short_i (res_o.short_frame)
);

FILE: dv/adtm_threshold_checker.sv
// Checker: watches both channels, predicts the thresholded results and compares them.
module adtm_threshold_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  adtm_in_if          smp,
  adtm_out_if         res,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned short_cnt_o,
  output int unsigned clip_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W    = adtm_pkg::DEF_SAMPLE_WIDTH;
  localparam int unsigned PRE  = adtm_pkg::DEF_PRE_WINDOW;
  localparam int unsigned POST = adtm_pkg::DEF_POST_WINDOW;
  localparam int unsigned SPAN = PRE + POST + 1;
  localparam longint VALUE_TOP = (longint'(1) << (W - 1)) - 1;

  typedef struct packed {
    logic [W-2:0] value;
    logic         last_result;
    logic         short_frame;
  } threshold_res_t;

  // Sample history, newest first, and its running total
  longint         hist [SPAN];
  longint         hist_total;
  int unsigned    fill;
  threshold_res_t thresh_q [$];
  threshold_res_t want;
  int unsigned    fails, checked, shorts, clips, pending;

  assign fail_cnt_o  = fails;
  assign pending_o   = pending;
  assign checked_o   = checked;
  assign short_cnt_o = shorts;
  assign clip_cnt_o  = clips;

  function automatic void clear_frame();
    for (int d = 0; d < SPAN; d++) hist[d] = 0;
    hist_total = 0;
    fill       = 0;
  endfunction

  function automatic longint newest_total(int unsigned cnt);
    longint acc = 0;
    for (int unsigned d = 0; d < cnt && d < SPAN; d++) acc += hist[d];
    return acc;
  endfunction

  // Sample minus truncated mean, clamped to [0, VALUE_TOP]
  function automatic void queue_threshold(longint x, longint total, longint len, logic last);
    longint         mean;
    longint         diff;
    threshold_res_t r;
    mean = (len > 0) ? total / len : 0;
    diff = x - mean;
    if (diff < 0) diff = 0;
    if (diff > VALUE_TOP) begin
      diff = VALUE_TOP;
      clips++;
    end
    r.value       = diff[W-2:0];
    r.last_result = last;
    r.short_frame = 1'b0;
    thresh_q.push_back(r);
  endfunction

  function automatic void take_sample(logic signed [W-1:0] s, logic last);
    int unsigned    pos;
    threshold_res_t r;
    pos = fill;
    hist_total -= hist[SPAN-1];
    for (int d = SPAN - 1; d > 0; d--) hist[d] = hist[d-1];
    hist[0] = longint'(s);
    hist_total += hist[0];
    if (fill < SPAN) fill++;

    if (!last) begin
      // head results use a growing window, later ones the full span less the newest
      if (pos >= POST) begin
        if (pos <= 2 * POST) queue_threshold(hist[POST], newest_total(pos), pos, 1'b0);
        else queue_threshold(hist[POST], hist_total - hist[0], SPAN - 1, 1'b0);
      end
    end else if (fill < SPAN) begin
      r = '{value: '0, last_result: 1'b1, short_frame: 1'b1};
      thresh_q.push_back(r);
      shorts++;
      clear_frame();
    end else begin
      // flush: one middle result, then the tail with shrinking windows
      queue_threshold(hist[POST], hist_total - hist[0], SPAN - 1, 1'b0);
      for (int d = POST; d > 0; d--)
        queue_threshold(hist[d-1], newest_total(d + POST), d + POST, d == 1);
      clear_frame();
    end
  endfunction

  initial begin
    fails   = 0;
    checked = 0;
    shorts  = 0;
    clips   = 0;
    pending = 0;
    clear_frame();
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      thresh_q.delete();
    end else begin
      if (smp.valid && smp.ready) take_sample(smp.sample, smp.last_sample);
      if (res.valid && res.ready) begin
        if (thresh_q.size() == 0) begin
          $error("unexpected result: value %0d last_result %0b short_frame %0b",
                 res.value, res.last_result, res.short_frame);
          fails++;
        end else begin
          want = thresh_q.pop_front();
          checked++;
          if (res.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, res.value);
            fails++;
          end
          if (res.last_result !== want.last_result) begin
            $error("last_result: expected %0b, got %0b", want.last_result, res.last_result);
            fails++;
          end
          if (res.short_frame !== want.short_frame) begin
            $error("short_frame: expected %0b, got %0b", want.short_frame, res.short_frame);
            fails++;
          end
        end
      end
    end
    pending = thresh_q.size();
  end

endmodule

FILE: dv/tb_adaptive_threshold_moving_mean.sv
// Testbench top: clock, reset, sample and result traffic, and the final verdict.
module tb_adaptive_threshold_moving_mean;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned W          = adtm_pkg::DEF_SAMPLE_WIDTH;
  localparam int unsigned RAND_ITEMS = 430;
  localparam int unsigned DRAIN_CYC  = 200;  // extra wait after the predicted results drain, for stray results

  logic clk_i;
  logic rst_ni;

  adtm_in_if  smp_if ();
  adtm_out_if res_if ();

  int unsigned fail_cnt, pending, checked, short_cnt, clip_cnt;
  int unsigned sent, frames;
  bit          smp_burst;   // sender runs without gaps for the current frame
  logic signed [W-1:0] frame_a [16];

  adaptive_threshold_moving_mean u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp_if),
    .res_o  (res_if)
  );

  adtm_threshold_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp         (smp_if),
    .res         (res_if),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked),
    .short_cnt_o (short_cnt),
    .clip_cnt_o  (clip_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Idle lengths: mostly none or short, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sample values: extremes, full-range noise, and realistic small Q16.16 levels
  function automatic logic signed [W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: begin
        case ($urandom_range(3))
          0:       return {1'b1, {(W-1){1'b0}}};
          1:       return {1'b0, {(W-1){1'b1}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return $urandom_range(0, 20 << 16);
    endcase
  endfunction

  // One sample request; valid is only lowered when a gap is taken
  task automatic send_sample(input logic signed [W-1:0] s, input logic last);
    int unsigned gap;
    gap = smp_burst ? 0 : idle_len();
    if (gap != 0) begin
      smp_if.valid       = 1'b0;
      smp_if.sample      = $urandom;     // junk while idle, must be ignored
      smp_if.last_sample = 1'($urandom_range(1));
      repeat (gap) @(negedge clk_i);
    end
    smp_if.valid       = 1'b1;
    smp_if.sample      = s;
    smp_if.last_sample = last;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    if (last) frames++;
  endtask

  task automatic send_frame(input int unsigned len);
    smp_burst = ($urandom_range(3) == 0);
    for (int unsigned i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // Result side: random back-pressure with occasional long open stretches
  initial begin
    res_if.ready = 1'b0;
    forever begin
      int unsigned stall;
      stall = ($urandom_range(7) == 0) ? 0 : idle_len();
      if (stall != 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      if ($urandom_range(7) == 0) repeat ($urandom_range(50, 150)) @(negedge clk_i);
      else repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned len;
    int unsigned r;
    rst_ni             = 1'b1;
    smp_if.valid       = 1'b0;
    smp_if.sample      = '0;
    smp_if.last_sample = 1'b0;
    sent               = 0;
    frames             = 0;
    smp_burst          = 1'b0;
    #1;
    rst_ni = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: a full 16-sample frame of rail values. A positive rail among
    // negative rails overflows and saturates; negative rails clamp to zero.
    for (int i = 0; i < 16; i++) frame_a[i] = {1'b1, {(W-1){1'b0}}};
    frame_a[3]  = '0;
    frame_a[7]  = {1'b0, {(W-1){1'b1}}};
    frame_a[10] = '1;
    frame_a[12] = {1'b0, {(W-1){1'b1}}};
    frame_a[15] = {1'b0, {(W-1){1'b1}}};
    for (int i = 0; i < 16; i++) send_sample(frame_a[i], i == 15);

    // Single-sample frame: short at once
    send_sample({1'b0, {(W-1){1'b1}}}, 1'b1);

    // Eight-sample frame: too few for any head result, so only the short-frame marker
    for (int i = 0; i < 8; i++) send_sample((i + 1) << 16, i == 7);

    // Random frames: mostly full length, some short, a few long ones
    while (sent < RAND_ITEMS) begin
      r = $urandom_range(99);
      if (r < 12)      len = $urandom_range(1, 15);
      else if (r < 22) len = $urandom_range(41, 90);
      else             len = $urandom_range(16, 40);
      if (len > RAND_ITEMS - sent) len = RAND_ITEMS - sent;
      send_frame(len);
    end
    smp_if.valid = 1'b0;

    // Let the last flush drain, then give stray results a chance to show
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);

    $display("Summary: %0d sample requests in %0d frames (%0d short)", sent, frames, short_cnt);
    $display("Summary: %0d results checked, %0d saturated at the top", checked, clip_cnt);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/adtm_pkg.sv
hw/rtl/adtm_stream_if.sv
hw/rtl/adaptive_threshold_moving_mean.sv
hw/rtl/adtm_checker.sv
dv/adtm_threshold_checker.sv
dv/tb_adaptive_threshold_moving_mean.sv
